// File: rtl/core/apit_pkg.sv
// Shared types, widths and constants of the pulse-interval tachometer.
`timescale 1ns / 1ps
`default_nettype none

package apit_pkg;

   // Channel count and derived index widths
   localparam int CHANNELS    = 2;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int OUT_LANES   = 2;
   localparam int LANE_W      = $clog2(OUT_LANES);

   // Field widths
   localparam int CMD_W       = 2;
   localparam int TS_W        = 64;
   localparam int IV_W        = 64;
   localparam int SPEED_W     = 33;
   localparam int ELAPSED_W   = 32;
   localparam int CAP_W       = 16;
   localparam int THR_W       = 25;
   localparam int MEAS_W      = 27;
   localparam int TICKS_W     = 5;
   localparam int STEP_W      = 36;
   localparam int DEC_PROD_W  = THR_W + 5;
   localparam int DEC_W       = DEC_PROD_W - 2;
   localparam int MUL_W       = DEC_W + 32;
   localparam int DIV_CNT_W   = $clog2(SPEED_W);

   // Stream widths
   localparam int REQ_TDATA_W = TS_W;
   localparam int REQ_TUSER_W = CMD_W + 1;
   localparam int RSP_USED_W  = 2 * IV_W + 2 * SPEED_W + ELAPSED_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;

   // Filter and reporting constants
   localparam logic [MEAS_W-1:0]    STARTUP_LIMIT     = 27'd80000000;
   localparam logic [THR_W-1:0]     STARTUP_THRESHOLD = 25'd2000000;
   localparam logic [TICKS_W-1:0]   STALE_TICKS       = 5'd20;
   localparam logic [19:0]          STALE_STEP        = 20'd800000;
   localparam logic [SPEED_W-1:0]   SPEED_NUMERATOR   = 33'd4800000000;
   localparam logic [4:0]           DECAY_NUM         = 5'd19;
   // ceil(2^34 / 5): exact floor(y / 5) for any 32-bit y
   localparam logic [31:0]          RECIP5            = 32'hCCCCCCCD;
   localparam int                   RECIP_SHIFT       = 34;
   localparam logic [CAP_W-1:0]     CAP_RESET         = 16'd10;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [CH_IDX_W-1:0] ch;
      logic [TS_W-1:0]     ts;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/core/apit_div.sv
// Restoring divider: fixed speed numerator over a 64-bit interval, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module apit_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [apit_pkg::IV_W-1:0]    divisor,
   output logic                        done,
   output logic [apit_pkg::SPEED_W-1:0] quotient
);
   import apit_pkg::*;

   logic [IV_W-1:0]      div_ff, div_in;
   logic [IV_W-1:0]      rem_ff, rem_in;
   logic [SPEED_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [IV_W:0]        trial;
   logic [IV_W:0]        diff;
   logic                 fits;

   // One restoring step per cycle, numerator bits shifted in from the top
   always_comb begin
      trial   = {rem_ff, quo_ff[SPEED_W-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = (trial >= {1'b0, div_ff});
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = SPEED_NUMERATOR;
         cnt_in  = DIV_CNT_W'(SPEED_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[IV_W-1:0] : trial[IV_W-1:0];
         quo_in = {quo_ff[SPEED_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // A zero interval reports zero speed
   assign done     = done_ff;
   assign quotient = (div_ff == '0) ? '0 : quo_ff;

endmodule

`default_nettype wire

// File: rtl/core/apit_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module apit_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  apit_pkg::item_type  push_item,
   output logic                full,
   output logic                q_valid,
   output apit_pkg::item_type  q_item,
   input  wire                 pop
);
   import apit_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = mem_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/apit_front.sv
// Front part: takes request transfers, classifies them and feeds the queue.
`timescale 1ns / 1ps
`default_nettype none

module apit_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [apit_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire [apit_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  wire                              q_full,
   output logic                             push,
   output apit_pkg::item_type               push_item
);
   import apit_pkg::*;

   logic             hold_valid_ff, hold_valid_in;
   item_type         hold_item_ff, hold_item_in;
   logic             accept;
   logic             keep;
   logic [CMD_W-1:0] cmd;
   logic             ch_bit;

   assign cmd        = req_tuser[CMD_W-1:0];
   assign ch_bit     = req_tuser[CMD_W];
   assign push       = hold_valid_ff && !q_full;
   assign req_tready = !hold_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push_item  = hold_item_ff;

   // Drop unused commands and edges on channels that are not built
   always_comb begin
      case (cmd)
         CMD_EDGE:            keep = (int'(ch_bit) < CHANNELS);
         CMD_TICK, CMD_START: keep = 1'b1;
         default:             keep = 1'b0;
      endcase
   end

   // Holding stage
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (accept) begin
         hold_valid_in = keep;
         hold_item_in  = '{cmd: cmd, ch: CH_IDX_W'(ch_bit), ts: req_tdata};
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/apit_back.sv
// Back part: channel state, glitch filter, report ticks, speed division and result register.
`timescale 1ns / 1ps
`default_nettype none

module apit_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [apit_pkg::CAP_W-1:0]        csr_data,
   input  wire                              q_valid,
   input  apit_pkg::item_type               q_item,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [apit_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import apit_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_GAP   = 4'd1;
   localparam logic [3:0] ST_FILT  = 4'd2;
   localparam logic [3:0] ST_DEC   = 4'd3;
   localparam logic [3:0] ST_DECW  = 4'd4;
   localparam logic [3:0] ST_STALE = 4'd5;
   localparam logic [3:0] ST_LOAD  = 4'd6;
   localparam logic [3:0] ST_WAIT  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   // Control and configuration
   logic [3:0]           state_ff, state_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [LANE_W-1:0]    lane_ff, lane_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Channel state
   logic [TS_W-1:0]      last_ff  [CHANNELS];
   logic [TS_W-1:0]      last_in  [CHANNELS];
   logic [THR_W-1:0]     thr_ff   [CHANNELS];
   logic [THR_W-1:0]     thr_in   [CHANNELS];
   logic [MEAS_W-1:0]    meas_ff  [CHANNELS];
   logic [MEAS_W-1:0]    meas_in  [CHANNELS];
   logic [TICKS_W-1:0]   ticks_ff [CHANNELS];
   logic [TICKS_W-1:0]   ticks_in [CHANNELS];
   logic [IV_W-1:0]      rep_ff   [CHANNELS];
   logic [IV_W-1:0]      rep_in   [CHANNELS];
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;

   // Working payload
   item_type             cur_ff, cur_in;
   logic [TS_W-1:0]      gap_ff, gap_in;
   logic [DEC_W-1:0]     dec_ff, dec_in;
   logic [MUL_W-1:0]     mul_ff, mul_in;
   logic [SPEED_W-1:0]   speed_ff [OUT_LANES];
   logic [SPEED_W-1:0]   speed_in [OUT_LANES];
   logic [ELAPSED_W-1:0] res_elapsed_ff, res_elapsed_in;
   logic [IV_W-1:0]      rsp_iv_ff [OUT_LANES];
   logic [IV_W-1:0]      rsp_iv_in [OUT_LANES];
   logic [SPEED_W-1:0]   rsp_speed_ff [OUT_LANES];
   logic [SPEED_W-1:0]   rsp_speed_in [OUT_LANES];
   logic [ELAPSED_W-1:0] rsp_elapsed_ff, rsp_elapsed_in;

   // Divider and helpers
   logic                 div_start;
   logic                 div_done;
   logic [SPEED_W-1:0]   div_quo;
   logic [IV_W-1:0]      lane_iv [OUT_LANES];
   logic                 startup;
   logic [MEAS_W-1:0]    gap_c;
   logic [THR_W-1:0]     thr_c;
   logic                 gap_ok;
   logic [DEC_PROD_W-1:0] dec_prod;
   logic [IV_W:0]        sum_tmp;
   logic                 out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Output lanes: channels that are not built report zero
   for (genvar k = 0; k < OUT_LANES; k++) begin : g_lane
      if (k < CHANNELS) begin : g_built
         assign lane_iv[k] = rep_ff[k];
      end else begin : g_absent
         assign lane_iv[k] = '0;
      end
   end

   apit_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (lane_iv[lane_ff]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Glitch filter decision for the current edge
   always_comb begin
      startup  = (gap_ff > TS_W'(STARTUP_LIMIT));
      gap_c    = startup ? STARTUP_LIMIT : gap_ff[MEAS_W-1:0];
      thr_c    = startup ? STARTUP_THRESHOLD : thr_ff[cur_ff.ch];
      gap_ok   = (gap_c > MEAS_W'(thr_c));
      dec_prod = DEC_PROD_W'(thr_c) * DEC_PROD_W'(DECAY_NUM);
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cap_in         = csr_valid ? csr_data : cap_ff;
      step_in        = STEP_W'(cap_ff) * STEP_W'(STALE_STEP);
      lane_in        = lane_ff;
      elapsed_in     = elapsed_ff;
      cur_in         = cur_ff;
      gap_in         = gap_ff;
      dec_in         = dec_ff;
      mul_in         = mul_ff;
      res_elapsed_in = res_elapsed_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      pop            = 1'b0;
      div_start      = 1'b0;
      sum_tmp        = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         last_in[c]  = last_ff[c];
         thr_in[c]   = thr_ff[c];
         meas_in[c]  = meas_ff[c];
         ticks_in[c] = ticks_ff[c];
         rep_in[c]   = rep_ff[c];
      end
      for (int k = 0; k < OUT_LANES; k++) begin
         speed_in[k]     = speed_ff[k];
         rsp_iv_in[k]    = rsp_iv_ff[k];
         rsp_speed_in[k] = rsp_speed_ff[k];
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cur_in = q_item;
               case (q_item.cmd)
                  CMD_EDGE:  state_in = ST_GAP;
                  CMD_TICK:  state_in = ST_STALE;
                  default:   elapsed_in = '0;
               endcase
            end
         end
         // Interval since the last accepted edge, wrapping
         ST_GAP: begin
            gap_in   = cur_ff.ts - last_ff[cur_ff.ch];
            state_in = ST_FILT;
         end
         ST_FILT: begin
            if (gap_ok) begin
               thr_in[cur_ff.ch]   = gap_c[MEAS_W-1:2];
               meas_in[cur_ff.ch]  = gap_c;
               last_in[cur_ff.ch]  = cur_ff.ts;
               ticks_in[cur_ff.ch] = '0;
               state_in            = ST_IDLE;
            end else begin
               dec_in   = dec_prod[DEC_PROD_W-1:2];
               state_in = ST_DEC;
            end
         end
         // Decay: floor(thr * 19 / 4) then divide by 5 through the reciprocal
         ST_DEC: begin
            mul_in   = MUL_W'(dec_ff) * MUL_W'(RECIP5);
            state_in = ST_DECW;
         end
         ST_DECW: begin
            thr_in[cur_ff.ch] = mul_ff[RECIP_SHIFT +: THR_W];
            state_in          = ST_IDLE;
         end
         // Report tick: refresh or grow every channel's interval
         ST_STALE: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (ticks_ff[c] <= STALE_TICKS) begin
                  rep_in[c]   = IV_W'(meas_ff[c]);
                  ticks_in[c] = ticks_ff[c] + 1'b1;
               end else begin
                  sum_tmp   = {1'b0, rep_ff[c]} + (IV_W + 1)'(step_ff);
                  rep_in[c] = sum_tmp[IV_W] ? '1 : sum_tmp[IV_W-1:0];
               end
            end
            res_elapsed_in = elapsed_ff;
            elapsed_in     = elapsed_ff + ELAPSED_W'(cap_ff);
            lane_in        = '0;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               speed_in[lane_ff] = div_quo;
               if (lane_ff == LANE_W'(OUT_LANES - 1)) begin
                  state_in = ST_OUT;
               end else begin
                  lane_in  = lane_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         // Hand the result to the output register once it is free
         ST_OUT: begin
            if (out_free) begin
               for (int k = 0; k < OUT_LANES; k++) begin
                  rsp_iv_in[k]    = lane_iv[k];
                  rsp_speed_in[k] = speed_ff[k];
               end
               rsp_elapsed_in = res_elapsed_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         lane_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         elapsed_ff   <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            last_ff[c]  <= '0;
            thr_ff[c]   <= '0;
            meas_ff[c]  <= '0;
            ticks_ff[c] <= '0;
            rep_ff[c]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
         elapsed_ff   <= elapsed_in;
         for (int c = 0; c < CHANNELS; c++) begin
            last_ff[c]  <= last_in[c];
            thr_ff[c]   <= thr_in[c];
            meas_ff[c]  <= meas_in[c];
            ticks_ff[c] <= ticks_in[c];
            rep_ff[c]   <= rep_in[c];
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      cur_ff         <= cur_in;
      gap_ff         <= gap_in;
      dec_ff         <= dec_in;
      mul_ff         <= mul_in;
      res_elapsed_ff <= res_elapsed_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      for (int k = 0; k < OUT_LANES; k++) begin
         speed_ff[k]     <= speed_in[k];
         rsp_iv_ff[k]    <= rsp_iv_in[k];
         rsp_speed_ff[k] <= rsp_speed_in[k];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_elapsed_ff, rsp_speed_ff[1], rsp_speed_ff[0],
                        rsp_iv_ff[1], rsp_iv_ff[0]};

endmodule

`default_nettype wire

// File: rtl/core/adaptive_pulse_interval_tachometer.sv
// Top level of the two-channel adaptive pulse-interval tachometer.
//
// Request channel (req_): tuser carries the command (edge, report tick, start)
// and the channel; tdata carries the 64-bit edge timestamp. Response channel
// (rsp_): one transfer per report tick with both intervals, both speeds and
// the elapsed milliseconds. csr_ writes the 16-bit report period; it is
// always ready; the user must write it while the block is idle (not enforced).
// A front stage classifies requests (unused commands and edges on absent
// channels are dropped) into a four-entry queue; the back part executes.
// The back part takes a start in its idle state, an edge through the gap and
// filter states (and the decay states when it is rejected), and a report tick
// through the stale update and two passes of one shared 33-step restoring divider.
// A finished result sits in the output register; while the receiver stalls,
// the back part keeps executing edges and starts until another report tick's
// result waits, and the queue keeps taking requests until it is full.
// Reset (synchronous) clears all channel state and elapsed time, empties the
// queue, drops any pending result and sets the report period to 10 ms.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_pulse_interval_tachometer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // tdata: timestamp[63:0]
   input  wire [apit_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: cmd[1:0], channel[2]
   input  wire [apit_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata: interval_first[63:0], interval_second[127:64], speed_first[160:128],
   //        speed_second[193:161], elapsed_ms[225:194], zero pad[231:226]
   output logic [apit_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [apit_pkg::CAP_W-1:0]        csr_data
);
   import apit_pkg::*;

   logic     push;
   item_type push_item;
   logic     q_full;
   logic     q_valid;
   item_type q_item;
   logic     pop;

   apit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   apit_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (pop)
   );

   apit_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/core/apit_checker.sv
// Port-level assertions for the tachometer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module apit_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire [apit_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input wire [apit_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [apit_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire                              csr_valid,
   input wire                              csr_ready,
   input wire [apit_pkg::CAP_W-1:0]        csr_data
);
   import apit_pkg::*;

   localparam int IV1_LO = IV_W;
   localparam int SP0_LO = 2 * IV_W;
   localparam int SP1_LO = 2 * IV_W + SPEED_W;

   logic [IV_W-1:0]    iv0;
   logic [IV_W-1:0]    iv1;
   logic [SPEED_W-1:0] sp0;
   logic [SPEED_W-1:0] sp1;

   assign iv0 = rsp_tdata[IV_W-1:0];
   assign iv1 = rsp_tdata[IV1_LO +: IV_W];
   assign sp0 = rsp_tdata[SP0_LO +: SPEED_W];
   assign sp1 = rsp_tdata[SP1_LO +: SPEED_W];

   // A stalled result is held unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // Reset discards any pending result
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Zero interval must give zero speed
   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (iv0 == '0 || iv1 == '0) |->
         (iv0 != '0 || sp0 == '0) && (iv1 != '0 || sp1 == '0))
      else $error("non-zero speed for zero interval");

   // Speed never exceeds the numerator
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> sp0 <= SPEED_NUMERATOR && sp1 <= SPEED_NUMERATOR)
      else $error("speed out of range");

   // A non-zero first interval of at most the numerator gives a non-zero first speed
   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && iv0 != '0 && iv0 <= IV_W'(SPEED_NUMERATOR) |-> sp0 != '0)
      else $error("zero speed for short interval");

endmodule

bind adaptive_pulse_interval_tachometer apit_checker u_apit_checker (.*);

`default_nettype wire
